// File: src/wcad_pkg.sv
// ============================================================================
// wcad_pkg: shared constants for the waveform column averaging decimator
// Field widths, register reset values, register indexes and default sizes.
// ============================================================================
package wcad_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 1024;
  localparam int unsigned ROW_BITS_DEF   = 12;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned COLS_W   = 11;
  localparam int unsigned GAIN_W   = 10;
  localparam int unsigned CENTER_W = 12;
  localparam int unsigned COL_W    = 11;

  localparam int unsigned PROD_W     = SAMPLE_W + GAIN_W;
  localparam int unsigned Q_FRAC     = 15;
  localparam int unsigned ROUND_HALF = 16384;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [LEN_W-1:0]    LEN_RST    = 11'd400;
  localparam logic [COLS_W-1:0]   COLS_RST   = 11'd17;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 10'd100;
  localparam logic [CENTER_W-1:0] CENTER_RST = 12'd503;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_WINDOW_LEN = 2'd0;
  localparam reg_idx_t REG_COLUMNS    = 2'd1;
  localparam reg_idx_t REG_GAIN       = 2'd2;
  localparam reg_idx_t REG_CENTER     = 2'd3;

endpackage

// File: src/wcad_smul.sv
// ============================================================================
// wcad_smul: bit-serial shift-and-add multiplier
// Consumes one multiplier bit per cycle until all B_W bits are used.
// ============================================================================
module wcad_smul #(
  parameter int unsigned A_W = 16,
  parameter int unsigned B_W = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               busy_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]   a_q, a_d;
  logic [B_W-1:0]   b_q, b_d;
  logic [P_W-1:0]   prod_q, prod_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    prod_d = prod_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      a_d    = P_W'(a_i);
      b_d    = b_i;
      prod_d = '0;
      cnt_d  = CNT_W'(B_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        prod_d = prod_q + a_q;
      end
      a_d   = {a_q[P_W-2:0], 1'b0};
      b_d   = b_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= prod_d;
  end

  assign busy_o = busy_q;
  assign prod_o = prod_q;

endmodule

// File: src/wcad_sdiv.sv
// ============================================================================
// wcad_sdiv: bit-serial restoring divider
// Shifts in one numerator bit per cycle until all N_W bits are used.
// ============================================================================
module wcad_sdiv #(
  parameter int unsigned N_W = 23,
  parameter int unsigned D_W = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic           busy_o,
  output logic [N_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   num_q, num_d;
  logic [D_W-1:0]   rem_q, rem_d;
  logic [D_W-1:0]   den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             fits;

  always_comb begin
    trial  = {rem_q, num_q[N_W-1]};
    diff   = trial - {1'b0, den_q};
    fits   = trial >= {1'b0, den_q};
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(N_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[D_W-1:0] : trial[D_W-1:0];
      num_d = {num_q[N_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = num_q;

endmodule

// File: src/waveform_column_average_decimator.sv
// ============================================================================
// waveform_column_average_decimator: audio samples to averaged screen points
// Maps each sample to a screen row and a column of its window, averages the
// rows that share a column and emits one point per finished column.
// ============================================================================
// Samples are taken one at a time. Each sample runs through the row and
// column multipliers, then the shared serial divider, which computes the
// column and every mean in turn. A sample that starts a new column within the
// window first emits the point of the finished column, and the last sample of
// a window always emits one. A point waits for the output register to drain
// before it is delivered, and a finished point waits in the output register
// while the next sample is taken.
module waveform_column_average_decimator #(
  parameter int unsigned MAX_WINDOW = wcad_pkg::MAX_WINDOW_DEF,
  parameter int unsigned ROW_BITS   = wcad_pkg::ROW_BITS_DEF,
  localparam int unsigned OUT_W     = ((wcad_pkg::COL_W + ROW_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [wcad_pkg::SAMPLE_W-1:0] s_axis_tdata,   // sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_W-1:0]              m_axis_tdata,   // column, mean_row, zero fill
  output logic                          m_axis_tlast,   // window_end
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wcad_pkg::ADDR_W-1:0]   paddr,
  input  logic [wcad_pkg::DATA_W-1:0]   pwdata,
  output logic [wcad_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  import wcad_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_WINDOW);
  localparam int unsigned WL_W   = IDX_W + 1;
  localparam int unsigned DW     = IDX_W + 2;
  localparam int unsigned SUM_W  = ROW_BITS + IDX_W;
  localparam int unsigned NW     = IDX_W + ((ROW_BITS + 1 > COLS_W + 1) ? ROW_BITS + 1
                                                                        : COLS_W + 1);
  localparam int unsigned CMP_W  = (LEN_W > WL_W) ? LEN_W : WL_W;
  localparam int unsigned ROWC_W = (ROW_BITS + 2 > CENTER_W + 2) ? ROW_BITS + 2
                                                                 : CENTER_W + 2;
  localparam int unsigned CMUL_W = IDX_W + COLS_W;
  localparam int unsigned RMAG_W = PROD_W + 1 - Q_FRAC;

  localparam logic [ROWC_W-1:0] ROW_TOP = ROWC_W'((1 << ROW_BITS) - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DIVC   = 3'd2;
  localparam logic [2:0] ST_DIVM   = 3'd3;
  localparam logic [2:0] ST_ADD    = 3'd4;
  localparam logic [2:0] ST_MSTART = 3'd5;

  // Configuration registers.
  logic [LEN_W-1:0]    len_q;
  logic [COLS_W-1:0]   cols_q;
  logic [GAIN_W-1:0]   gain_q;
  logic [CENTER_W-1:0] center_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LEN_RST;
      cols_q   <= COLS_RST;
      gain_q   <= GAIN_RST;
      center_q <= CENTER_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WINDOW_LEN: len_q    <= pwdata[LEN_W-1:0];
        REG_COLUMNS:    cols_q   <= pwdata[COLS_W-1:0];
        REG_GAIN:       gain_q   <= pwdata[GAIN_W-1:0];
        REG_CENTER:     center_q <= pwdata[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WINDOW_LEN: prdata = DATA_W'(len_q);
      REG_COLUMNS:    prdata = DATA_W'(cols_q);
      REG_GAIN:       prdata = DATA_W'(gain_q);
      REG_CENTER:     prdata = DATA_W'(center_q);
      default:        prdata = '0;
    endcase
  end

  // Sequencer and group state.
  logic [2:0]          state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [COL_W-1:0]    cur_q, cur_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [WL_W-1:0]     cnt_q, cnt_d;
  logic                emit_end_q, emit_end_d;
  logic                m_valid_q, m_valid_d;

  logic                neg_q, neg_d;
  logic                last_q, last_d;
  logic [WL_W-1:0]     wl_q, wl_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [COL_W-1:0]    m_col_q, m_col_d;
  logic [ROW_BITS-1:0] m_mean_q, m_mean_d;
  logic                m_last_q, m_last_d;

  logic                  s_acc;
  logic [CMP_W-1:0]      len_x;
  logic [WL_W-1:0]       wl_eff;
  logic [WL_W-1:0]       wl_m1;
  logic                  last_now;
  logic [IDX_W-1:0]      idx_now;
  logic                  s_neg;
  logic [SAMPLE_W-1:0]   s_mag;
  logic                  row_busy;
  logic                  col_busy;
  logic [PROD_W-1:0]     row_prod;
  logic [CMUL_W-1:0]     col_prod;
  logic [PROD_W:0]       rnd;
  logic [RMAG_W-1:0]     r_mag;
  logic [ROWC_W-1:0]     row_s;
  logic [ROW_BITS-1:0]   row_sat;
  logic                  div_start;
  logic                  div_busy;
  logic [NW-1:0]         div_num;
  logic [DW-1:0]         div_den;
  logic [NW-1:0]         div_quo;
  logic [COL_W-1:0]      col_new;
  logic                  deliver;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  always_comb begin
    len_x = CMP_W'(len_q);
    if (len_q == '0) begin
      wl_eff = WL_W'(1);
    end else if (len_x > CMP_W'(MAX_WINDOW)) begin
      wl_eff = WL_W'(MAX_WINDOW);
    end else begin
      wl_eff = len_x[WL_W-1:0];
    end
    wl_m1    = wl_eff - 1'b1;
    last_now = WL_W'(idx_q) >= wl_m1;
    idx_now  = last_now ? wl_m1[IDX_W-1:0] : idx_q;
    s_neg    = s_axis_tdata[SAMPLE_W-1];
    s_mag    = s_neg ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
  end

  wcad_smul #(
    .A_W (SAMPLE_W),
    .B_W (GAIN_W)
  ) u_mul_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_acc),
    .a_i     (s_mag),
    .b_i     (gain_q),
    .busy_o  (row_busy),
    .prod_o  (row_prod)
  );

  wcad_smul #(
    .A_W (IDX_W),
    .B_W (COLS_W)
  ) u_mul_col (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_acc),
    .a_i     (idx_now),
    .b_i     (cols_q),
    .busy_o  (col_busy),
    .prod_o  (col_prod)
  );

  // Row: round half away from zero, offset by the centre line, saturate.
  always_comb begin
    rnd   = (PROD_W + 1)'(row_prod) + (PROD_W + 1)'(ROUND_HALF);
    r_mag = rnd[PROD_W:Q_FRAC];
    if (neg_q) begin
      row_s = ROWC_W'(center_q) - ROWC_W'(r_mag);
    end else begin
      row_s = ROWC_W'(center_q) + ROWC_W'(r_mag);
    end
    if (row_s[ROWC_W-1]) begin
      row_sat = '0;
    end else if (row_s > ROW_TOP) begin
      row_sat = '1;
    end else begin
      row_sat = row_s[ROW_BITS-1:0];
    end
  end

  assign div_num = (state_q == ST_MUL) ? (NW'({col_prod, 1'b0}) + NW'(wl_q))
                                       : (NW'({sum_q, 1'b0}) + NW'(cnt_q));
  assign div_den = (state_q == ST_MUL) ? {wl_q, 1'b0} : {cnt_q, 1'b0};

  wcad_sdiv #(
    .N_W (NW),
    .D_W (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign col_new = div_quo[COL_W-1:0];

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cur_d      = cur_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    emit_end_d = emit_end_q;
    neg_d      = neg_q;
    last_d     = last_q;
    wl_d       = wl_q;
    row_d      = row_q;
    col_d      = col_q;
    div_start  = 1'b0;
    deliver    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          neg_d   = s_neg;
          last_d  = last_now;
          wl_d    = wl_eff;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!row_busy && !col_busy) begin
          row_d     = row_sat;
          div_start = 1'b1;
          state_d   = ST_DIVC;
        end
      end
      ST_DIVC: begin
        if (!div_busy) begin
          col_d = col_new;
          if ((cnt_q != '0) && (col_new != cur_q)) begin
            div_start  = 1'b1;
            emit_end_d = 1'b0;
            state_d    = ST_DIVM;
          end else begin
            state_d = ST_ADD;
          end
        end
      end
      ST_DIVM: begin
        if (!div_busy && (!m_valid_q || m_axis_tready)) begin
          deliver = 1'b1;
          sum_d   = '0;
          cnt_d   = '0;
          if (emit_end_q) begin
            cur_d   = '0;
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        if (cnt_q == '0) begin
          cur_d = col_q;
        end
        sum_d = sum_q + SUM_W'(row_q);
        cnt_d = cnt_q + 1'b1;
        if (last_q) begin
          state_d = ST_MSTART;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_MSTART: begin
        div_start  = 1'b1;
        emit_end_d = 1'b1;
        state_d    = ST_DIVM;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_col_d   = m_col_q;
    m_mean_d  = m_mean_q;
    m_last_d  = m_last_q;
    if (deliver) begin
      m_valid_d = 1'b1;
      m_col_d   = cur_q;
      m_mean_d  = div_quo[ROW_BITS-1:0];
      m_last_d  = emit_end_q;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      cur_q      <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      emit_end_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      cur_q      <= cur_d;
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      emit_end_q <= emit_end_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    last_q   <= last_d;
    wl_q     <= wl_d;
    row_q    <= row_d;
    col_q    <= col_d;
    m_col_q  <= m_col_d;
    m_mean_q <= m_mean_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({m_mean_q, m_col_q});
  assign m_axis_tlast  = m_last_q;

endmodule

// File: src/wcad_checker.sv
// ============================================================================
// wcad_checker: port-level checks for the decimator
// Watches the stream ports over time; attached to the top level by bind.
// ============================================================================
module wcad_checker #(
  parameter int unsigned OUT_W = 24
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  logic s_acc;
  logic m_stall;

  assign s_acc   = s_axis_tvalid & s_axis_tready;
  assign m_stall = m_axis_tvalid & ~m_axis_tready;

  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_stall |=> m_axis_tvalid)
    else $error("Output beat withdrawn while stalled.");

  a_out_beat_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_stall |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("Output beat changed while stalled.");

  a_one_sample_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("A second sample was taken while one was still being processed.");

  a_no_instant_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !(m_axis_tvalid && !$past(m_stall)))
    else $error("A point appeared straight after a sample beat.");

endmodule

bind waveform_column_average_decimator wcad_checker #(
  .OUT_W (OUT_W)
) u_wcad_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
